[design/blcb_pkg.sv]
// Shared types and constants for the block linear complexity binner.
`timescale 1ns / 1ps
`default_nettype none

package blcb_pkg;

  localparam int WORD_BITS     = 64;
  localparam int LEN_W         = 13;
  localparam int BIN_W         = 3;
  localparam int COUNT_W       = 24;
  localparam int NUM_CLASSES   = 7;
  localparam int BIN_CENTER    = 3;
  localparam int MAX_BLOCK_DEF = 4096;

  localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(500);
  localparam logic [LEN_W-1:0]   LEN_MIN   = LEN_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STEP,
    ST_REPORT
  } state_t;

  // Commands broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic clear;
    logic shift;
    logic step;
    logic flip;
    logic grow;
  } cell_ctl_t;

endpackage

`default_nettype wire

[design/blcb_cell.sv]
// One 64-bit slice of the sequence, connection polynomial and shifted previous polynomial.
`timescale 1ns / 1ps
`default_nettype none

module blcb_cell #(
  parameter int INDEX = 0,
  parameter int LIVE  = blcb_pkg::WORD_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire blcb_pkg::cell_ctl_t ctl,
  input  wire logic                r_in,
  input  wire logic                c_in,
  input  wire logic                d_in,
  input  wire logic                acc_in,
  output logic                     r_top,
  output logic                     c_top,
  output logic                     d_top,
  output logic                     acc_out
);

  localparam int W = blcb_pkg::WORD_BITS;
  // Bits at or above the block size limit are dropped, as the polynomials are truncated there.
  localparam logic [W-1:0] MASK   = {W{1'b1}} >> (W - LIVE);
  localparam logic [W-1:0] C_INIT = (INDEX == 0) ? W'(1) : '0;
  localparam logic [W-1:0] D_INIT = (INDEX == 0) ? W'(2) : '0;

  logic [W-1:0] seq;
  logic [W-1:0] conn;
  logic [W-1:0] delta;
  logic         acc;

  // The sequence is held reversed: bit i of the row is the bit i positions back.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      seq <= {seq[W-2:0], r_in} & MASK;
    end
  end

  // delta holds the previous polynomial already multiplied by x to the pending shift.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      conn  <= C_INIT & MASK;
      delta <= D_INIT & MASK;
    end else if (ctl.step) begin
      if (ctl.flip) begin
        conn <= conn ^ delta;
      end
      if (ctl.flip && ctl.grow) begin
        delta <= {conn[W-2:0], c_in} & MASK;
      end else begin
        delta <= {delta[W-2:0], d_in} & MASK;
      end
    end
  end

  // Discrepancy parity ripples one cell per cycle toward the top of the row.
  always_ff @(posedge clk) begin
    acc <= acc_in ^ (^(conn & seq));
  end

  assign r_top   = seq[W-1];
  assign c_top   = conn[W-1];
  assign d_top   = delta[W-1];
  assign acc_out = acc;

endmodule

`default_nettype wire

[design/block_linear_complexity_binner.sv]
// Top level: sequencer, block bookkeeping, deviation classing and the row of cells.
// Each input bit passes through three phases, with NCELLS = MAX_BLOCK / 64 rounded up:
// the bit is shifted into the row, the discrepancy parity ripples down the chain of
// cells, and the polynomial update is applied in all cells at once.
// On the last bit of a block the result register is loaded in a report step, after any wait for
// the previous result to be taken. Synchronous reset clears control state, polynomials
// and class counts and sets the block length to 500; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module block_linear_complexity_binner #(
  parameter int MAX_BLOCK = blcb_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [blcb_pkg::LEN_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         data_bit,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [blcb_pkg::LEN_W-1:0]        complexity,
  output logic [blcb_pkg::BIN_W-1:0]        bin_index,
  output logic [blcb_pkg::COUNT_W-1:0]      bin_count
);

  localparam int W      = blcb_pkg::WORD_BITS;
  localparam int LW     = blcb_pkg::LEN_W;
  localparam int CW     = blcb_pkg::COUNT_W;
  localparam int NCELLS = (MAX_BLOCK + W - 1) / W;
  localparam int SCW    = $clog2(NCELLS + 1);

  blcb_pkg::state_t    state;
  blcb_pkg::state_t    state_next;
  blcb_pkg::cell_ctl_t ctl;

  logic [SCW-1:0] scan_cnt;
  logic [LW-1:0]  bit_pos;
  logic [LW-1:0]  cur_len;
  logic [LW-1:0]  blk_len;
  logic [CW-1:0]  counts [blcb_pkg::NUM_CLASSES];

  logic [NCELLS-1:0] r_link;
  logic [NCELLS-1:0] c_link;
  logic [NCELLS-1:0] d_link;
  logic [NCELLS:0]   acc_link;

  logic                           flip;
  logic                           grow;
  logic                           last_bit;
  logic                           scan_done;
  logic                           report_go;
  logic [LW-1:0]                  m_eff;
  logic [LW:0]                    half;
  logic signed [LW+1:0]           dev;
  logic signed [LW+1:0]           biased;
  logic [blcb_pkg::BIN_W-1:0]     bin_sel;
  logic [CW-1:0]                  cnt_inc;

  // Row of cells.
  assign acc_link[0] = 1'b0;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    localparam int REST = MAX_BLOCK - k * W;
    localparam int LIVE = (REST >= W) ? W : REST;
    logic r_from;
    logic c_from;
    logic d_from;
    if (k == 0) begin : g_first
      assign r_from = data_bit;
      assign c_from = 1'b0;
      assign d_from = 1'b0;
    end else begin : g_rest
      assign r_from = r_link[k-1];
      assign c_from = c_link[k-1];
      assign d_from = d_link[k-1];
    end
    blcb_cell #(
      .INDEX (k),
      .LIVE  (LIVE)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .r_in    (r_from),
      .c_in    (c_from),
      .d_in    (d_from),
      .acc_in  (acc_link[k]),
      .r_top   (r_link[k]),
      .c_top   (c_link[k]),
      .d_top   (d_link[k]),
      .acc_out (acc_link[k+1])
    );
  end

  // Block bookkeeping and classing.
  always_comb begin
    if (blk_len < blcb_pkg::LEN_MIN) begin
      m_eff = blcb_pkg::LEN_MIN;
    end else if (32'(blk_len) > MAX_BLOCK) begin
      m_eff = LW'(MAX_BLOCK);
    end else begin
      m_eff = blk_len;
    end
  end

  assign flip      = acc_link[NCELLS];
  assign grow      = (cur_len <= (bit_pos >> 1));
  assign last_bit  = ((bit_pos + LW'(1)) == m_eff);
  assign scan_done = (scan_cnt == SCW'(NCELLS - 1));

  // Half of M rounded up: M/2 for even M, (M+1)/2 for odd M.
  assign half = ({1'b0, m_eff} + (LW + 1)'(m_eff[0])) >> 1;

  always_comb begin
    if (m_eff[0]) begin
      dev = signed'({1'b0, half}) - signed'({2'b00, cur_len});
    end else begin
      dev = signed'({2'b00, cur_len}) - signed'({1'b0, half});
    end
    biased = dev + signed'((LW + 2)'(blcb_pkg::BIN_CENTER));
    priority if (biased < 0) begin
      bin_sel = '0;
    end else if (biased > (blcb_pkg::NUM_CLASSES - 1)) begin
      bin_sel = blcb_pkg::BIN_W'(blcb_pkg::NUM_CLASSES - 1);
    end else begin
      bin_sel = biased[blcb_pkg::BIN_W-1:0];
    end
  end

  assign cnt_inc = (counts[bin_sel] == blcb_pkg::COUNT_MAX) ? counts[bin_sel]
                                                             : counts[bin_sel] + CW'(1);

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      blcb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = blcb_pkg::ST_SCAN;
        end
      end
      blcb_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = blcb_pkg::ST_STEP;
        end
      end
      blcb_pkg::ST_STEP: begin
        state_next = last_bit ? blcb_pkg::ST_REPORT : blcb_pkg::ST_IDLE;
      end
      blcb_pkg::ST_REPORT: begin
        if (!out_valid || out_ready) begin
          state_next = blcb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = blcb_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready  = 1'b0;
    report_go = 1'b0;
    ctl       = '0;
    unique case (state)
      blcb_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.shift = in_valid;
      end
      blcb_pkg::ST_SCAN: begin
      end
      blcb_pkg::ST_STEP: begin
        ctl.step = 1'b1;
        ctl.flip = flip;
        ctl.grow = grow;
      end
      blcb_pkg::ST_REPORT: begin
        report_go = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
    ctl.clear = cfg_write || report_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= blcb_pkg::ST_IDLE;
      scan_cnt  <= '0;
      bit_pos   <= '0;
      cur_len   <= '0;
      blk_len   <= blcb_pkg::LEN_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < blcb_pkg::NUM_CLASSES; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_write) begin
        blk_len <= cfg_data;
      end
      if (state == blcb_pkg::ST_SCAN) begin
        scan_cnt <= scan_cnt + SCW'(1);
      end else begin
        scan_cnt <= '0;
      end
      if (cfg_write || report_go) begin
        bit_pos <= '0;
        cur_len <= '0;
      end else if (state == blcb_pkg::ST_STEP) begin
        if (flip && grow) begin
          cur_len <= bit_pos + LW'(1) - cur_len;
        end
        if (!last_bit) begin
          bit_pos <= bit_pos + LW'(1);
        end
      end
      if (report_go) begin
        out_valid       <= 1'b1;
        counts[bin_sel] <= cnt_inc;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (report_go) begin
      complexity <= cur_len;
      bin_index  <= bin_sel;
      bin_count  <= cnt_inc;
    end
  end

endmodule

`default_nettype wire

[design/blcb_checker.sv]
// Port-level checks for the block linear complexity binner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module blcb_port_checks (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [blcb_pkg::LEN_W-1:0]    complexity,
  input wire logic [blcb_pkg::BIN_W-1:0]    bin_index,
  input wire logic [blcb_pkg::COUNT_W-1:0]  bin_count
);

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A bit needs the full discrepancy pass, so the input closes after every transfer.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open right after a transfer");

  // A result is loaded only from the report step, never while the input is open.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while input was open");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(complexity) && $stable(bin_index) && $stable(bin_count)))
    else $error("stalled result changed");

endmodule

bind block_linear_complexity_binner blcb_port_checks u_blcb_checker (.*);

`default_nettype wire

[tb/blcb_checker.sv]
// Checker for the linear complexity binner: tracks Berlekamp-Massey state and compares results.
`timescale 1ns / 1ps

module blcb_checker
  import blcb_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [LEN_W-1:0]   cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               data_bit,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [LEN_W-1:0]   complexity,
  input  logic [BIN_W-1:0]   bin_index,
  input  logic [COUNT_W-1:0] bin_count,
  output int                 mismatches,
  output int                 pending,
  output int                 bits_taken,
  output int                 blocks_checked
);

  typedef struct packed {
    logic [LEN_W-1:0]   complexity;
    logic [BIN_W-1:0]   bin;
    logic [COUNT_W-1:0] count;
  } block_result_t;

  block_result_t blocks_due[$];

  bit [MAX_BLOCK-1:0] block_bits;
  bit [MAX_BLOCK-1:0] conn_poly;
  bit [MAX_BLOCK-1:0] prev_poly;
  int unsigned        lin_cx;
  int unsigned        change_pos;
  bit                 change_seen;
  int unsigned        bit_pos;
  logic [LEN_W-1:0]   len_reg;
  logic [COUNT_W-1:0] class_count [NUM_CLASSES];

  function automatic void restart_block();
    block_bits  = '0;
    conn_poly   = MAX_BLOCK'(1);
    prev_poly   = MAX_BLOCK'(1);
    lin_cx      = 0;
    change_pos  = 0;
    change_seen = 1'b0;
    bit_pos     = 0;
  endfunction

  function automatic int unsigned block_size();
    if (len_reg < LEN_MIN) return LEN_MIN;
    if (len_reg > MAX_BLOCK) return MAX_BLOCK;
    return len_reg;
  endfunction

  // One Berlekamp-Massey step on the new bit; queues a result when the block is full.
  function automatic void absorb_bit(input bit b);
    int unsigned   m, n, shift, span, i, j;
    bit            disc;
    bit [MAX_BLOCK-1:0] saved;
    int            dev, cls;
    block_result_t r;
    m = block_size();
    n = bit_pos;
    block_bits[n] = b;
    disc = 1'b0;
    for (i = 0; i <= lin_cx && i <= n; i++) disc ^= conn_poly[i] & block_bits[n - i];
    if (disc) begin
      if (change_seen) begin
        shift = n - change_pos;
        span  = change_pos + 1;
      end else begin
        shift = n + 1;
        span  = 1;
      end
      saved = conn_poly;
      for (j = 0; j < span; j++) begin
        if (prev_poly[j] && j + shift < MAX_BLOCK) conn_poly[j + shift] ^= 1'b1;
      end
      // The complexity grows only when the current register is at most half the prefix.
      if (lin_cx <= n / 2) begin
        prev_poly   = saved;
        lin_cx      = n + 1 - lin_cx;
        change_pos  = n;
        change_seen = 1'b1;
      end
    end
    n++;
    if (n < m) begin
      bit_pos = n;
      return;
    end
    if (m % 2 == 0) dev = int'(lin_cx) - int'(m / 2);
    else dev = int'((m + 1) / 2) - int'(lin_cx);
    cls = dev + BIN_CENTER;
    if (cls < 0) cls = 0;
    if (cls > NUM_CLASSES - 1) cls = NUM_CLASSES - 1;
    if (class_count[cls] != COUNT_MAX) class_count[cls]++;
    r.complexity = lin_cx[LEN_W-1:0];
    r.bin        = cls[BIN_W-1:0];
    r.count      = class_count[cls];
    blocks_due.push_back(r);
    restart_block();
  endfunction

  always @(posedge clk) begin : watch
    block_result_t got, want;
    if (rst) begin
      len_reg = LEN_RESET;
      for (int c = 0; c < NUM_CLASSES; c++) class_count[c] = '0;
      restart_block();
      blocks_due.delete();
    end else begin
      if (cfg_write) begin
        len_reg = cfg_data;
        restart_block();
      end
      if (in_valid && in_ready) begin
        absorb_bit(data_bit);
        bits_taken++;
      end
      if (out_valid && out_ready) begin
        got.complexity = complexity;
        got.bin        = bin_index;
        got.count      = bin_count;
        if (blocks_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result complexity %0d bin %0d count %0d", $realtime,
                     got.complexity, got.bin, got.count);
        end else begin
          want = blocks_due.pop_front();
          blocks_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: block %0d mismatch (expected/actual) complexity %0d/%0d ",
                        "bin %0d/%0d count %0d/%0d"}, $realtime, blocks_checked,
                       want.complexity, got.complexity, want.bin, got.bin,
                       want.count, got.count);
          end
        end
      end
    end
    pending = blocks_due.size();
  end

endmodule

[tb/testbench.sv]
// Top of the binner testbench: clock, reset, stimulus, receiver, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import blcb_pkg::*;

  localparam int SETTLE      = 200;
  localparam int HOLD_CYCLES = 2500;
  localparam int QUIET_LIMIT = 20000;

  typedef enum {PAT_RANDOM, PAT_SPARSE, PAT_PERIODIC, PAT_FLAT} pattern_kind_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [LEN_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               data_bit = 1'b0;
  logic               out_valid;
  logic               out_ready;
  logic [LEN_W-1:0]   complexity;
  logic [BIN_W-1:0]   bin_index;
  logic [COUNT_W-1:0] bin_count;

  int mismatches, pending, bits_taken, blocks_checked;
  int send_idle = 23;
  int recv_idle = 84;
  bit hold_req  = 1'b0;
  int items_sent = 0;
  int len_writes = 0;
  int quiet_cycles = 0;

  block_linear_complexity_binner #(.MAX_BLOCK(MAX_BLOCK_DEF)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_bit   (data_bit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .complexity (complexity),
    .bin_index  (bin_index),
    .bin_count  (bin_count)
  );

  blcb_checker #(.MAX_BLOCK(MAX_BLOCK_DEF)) complexity_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_bit       (data_bit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .complexity     (complexity),
    .bin_index      (bin_index),
    .bin_count      (bin_count),
    .mismatches     (mismatches),
    .pending        (pending),
    .bits_taken     (bits_taken),
    .blocks_checked (blocks_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: random back-pressure, plus a long hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_bit(input bit b);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_bit <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_bits(input int n, input bit [15:0] pat);
    for (int k = n - 1; k >= 0; k--) send_bit(pat[k]);
  endtask

  task automatic send_stream(input int n, input pattern_kind_t kind);
    bit [31:0] motif;
    int        period;
    bit        level;
    bit        b;
    motif  = $urandom;
    period = $urandom_range(1, 12);
    level  = $urandom_range(0, 1);
    for (int k = 0; k < n; k++) begin
      case (kind)
        PAT_SPARSE:   b = ($urandom_range(0, 15) == 0);
        PAT_PERIODIC: b = motif[k % period];
        PAT_FLAT:     b = level;
        default:      b = $urandom_range(0, 1);
      endcase
      send_bit(b);
    end
  endtask

  // The block may still be chewing on a bit that finishes no block, hence the settle time.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_block_length(input logic [LEN_W-1:0] value);
    cfg_data  <= value;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    len_writes++;
  endtask

  task automatic run_phase(input int s_idle, input int r_idle, input int budget);
    int start_count, len, eff, blocks;
    send_idle   = s_idle;
    recv_idle   = r_idle;
    start_count = items_sent;
    while (items_sent - start_count < budget) begin
      case ($urandom_range(0, 19))
        0:          len = $urandom_range(0, 1);
        1, 2:       len = $urandom_range(65, 160);
        3, 4, 5, 6: len = $urandom_range(17, 64);
        default:    len = $urandom_range(2, 16);
      endcase
      eff = (len < 2) ? 2 : len;
      drain();
      set_block_length(len[LEN_W-1:0]);
      blocks = (eff > 64) ? 1 : $urandom_range(1, 6);
      repeat (blocks) send_stream(eff, pattern_kind_t'($urandom_range(0, 3)));
      // A trailing partial block is thrown away by the next length write.
      if ($urandom_range(0, 3) == 0) send_stream($urandom_range(1, eff - 1), PAT_RANDOM);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Power-on block length.
    send_stream(int'(LEN_RESET), PAT_RANDOM);

    drain();
    set_block_length(LEN_W'(2));
    send_bits(8, 16'b00_01_10_11);
    drain();
    set_block_length('0);
    send_bits(2, 16'b11);
    drain();
    set_block_length(LEN_W'(1));
    send_bits(2, 16'b10);
    drain();
    // An all-zero even block lands in the lowest class, an all-zero odd one in the highest.
    set_block_length(LEN_W'(6));
    send_bits(6, 16'b000000);
    drain();
    set_block_length(LEN_W'(5));
    send_bits(5, 16'b00000);
    drain();
    set_block_length(LEN_W'(MAX_BLOCK_DEF));
    send_bits(2, 16'b01);

    run_phase(23, 84, 275);
    run_phase(84, 23, 275);
    run_phase(0, 0, 275);

    // Hold the output long enough for finished blocks to back up into the input.
    drain();
    set_block_length(LEN_W'(2));
    hold_req = 1'b1;
    send_stream(40, PAT_RANDOM);

    drain();
    $display("Run covered %0d bits in %0d checked blocks over %0d length writes,",
             bits_taken, blocks_checked, len_writes);
    $display("from clamped short lengths up to 500-bit blocks and a long output hold, %0s %0d.",
             "mismatches:", mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
